// ===== design/hnm_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, command and status types of the height map normal unit
package hnm_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int MAX_RADIUS  = 32;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    typedef enum logic [2:0] {
        CFG_GRID_WIDTH    = 3'd0,
        CFG_GRID_HEIGHT   = 3'd1,
        CFG_WINDOW_RADIUS = 3'd2,
        CFG_GAIN_X        = 3'd3,
        CFG_GAIN_Y        = 3'd4,
        CFG_RIGHT_HANDED  = 3'd5,
        CFG_Y_UP          = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MS_XL,
        MS_XR,
        MS_YD,
        MS_YU
    } mem_sel_t;

    typedef enum logic [1:0] {
        MUL_DX,
        MUL_DY,
        MUL_AX,
        MUL_AY
    } mul_sel_t;

    typedef enum logic [2:0] {
        DK_SLOPE_X,
        DK_SLOPE_Y,
        DK_NORM_X,
        DK_NORM_Y,
        DK_NORM_Z
    } div_kind_t;

    typedef struct packed {
        logic      mem_write;
        logic      latch_query;
        mem_sel_t  mem_sel;
        logic      cap_en;
        mem_sel_t  cap_sel;
        logic      mul_en;
        mul_sel_t  mul_sel;
        logic      sum_init;
        logic      sum_add;
        logic      div_load;
        logic      div_store;
        div_kind_t div_kind;
        logic      sqrt_load;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic sqrt_busy;
    } status_t;

endpackage

// ===== design/hnm_ram.sv =====
`timescale 1ns / 1ps
// generic simple dual port ram with registered read
module hnm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/hnm_datapath.sv =====
`timescale 1ns / 1ps
// datapath: config registers, height store, multiplier, divider, square root, encoders
module hnm_datapath
    import hnm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic [7:0]  pixel_x,
    input  logic [7:0]  pixel_y,
    input  logic [15:0] height_sample,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    output logic [15:0] normal_x_code,
    output logic [15:0] normal_y_code,
    output logic [15:0] normal_z_code,
    output logic [15:0] export_red,
    output logic [15:0] export_green,
    output logic [15:0] export_blue
);

    function automatic logic [15:0] encode(input logic [16:0] off, input logic neg);
        logic [16:0] t;
        begin
            if (neg)
            begin
                t = (off >= 17'd32768) ? 17'd0 : (17'd32768 - off);
            end
            else
            begin
                t = (off >= 17'd32767) ? 17'd65535 : (17'd32768 + off);
            end
            return t[15:0];
        end
    endfunction

    function automatic logic [16:0] sat17(input logic [47:0] q);
        return (|q[47:17]) ? 17'h1FFFF : q[16:0];
    endfunction

    // configuration
    logic [8:0]  gw_reg, gh_reg;
    logic [5:0]  rad_reg;
    logic [23:0] gx_reg, gy_reg;
    logic        rh_reg, yup_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg  <= 9'd256;
            gh_reg  <= 9'd256;
            rad_reg <= 6'd1;
            gx_reg  <= 24'd256;
            gy_reg  <= 24'd256;
            rh_reg  <= 1'b0;
            yup_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_GRID_WIDTH:    gw_reg  <= cfg_data[8:0];
                CFG_GRID_HEIGHT:   gh_reg  <= cfg_data[8:0];
                CFG_WINDOW_RADIUS: rad_reg <= cfg_data[5:0];
                CFG_GAIN_X:        gx_reg  <= cfg_data;
                CFG_GAIN_Y:        gy_reg  <= cfg_data;
                CFG_RIGHT_HANDED:  rh_reg  <= cfg_data[0];
                CFG_Y_UP:          yup_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // query coordinates and window geometry
    logic [7:0] qx_reg, qy_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_query)
        begin
            qx_reg <= pixel_x;
            qy_reg <= pixel_y;
        end
    end

    logic [8:0] w_eff, h_eff, wm1, hm1, xq, yq, r9;
    logic [8:0] xl, xr, yd, yu, xsum, ysum, span_x9, span_y9;
    logic [6:0] span_x, span_y;

    always_comb
    begin
        w_eff = (gw_reg == 9'd0) ? 9'd1 : ((gw_reg > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : gw_reg);
        h_eff = (gh_reg == 9'd0) ? 9'd1 : ((gh_reg > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : gh_reg);
        wm1   = w_eff - 9'd1;
        hm1   = h_eff - 9'd1;
        xq    = ({1'b0, qx_reg} > wm1) ? wm1 : {1'b0, qx_reg};
        yq    = ({1'b0, qy_reg} > hm1) ? hm1 : {1'b0, qy_reg};
        r9    = (rad_reg > 6'(MAX_RADIUS)) ? 9'(MAX_RADIUS) : {3'b000, rad_reg};
        xl    = (xq > r9) ? (xq - r9) : 9'd0;
        yd    = (yq > r9) ? (yq - r9) : 9'd0;
        xsum  = xq + r9;
        ysum  = yq + r9;
        xr    = (xsum > wm1) ? wm1 : xsum;
        yu    = (ysum > hm1) ? hm1 : ysum;
        span_x9 = xr - xl;
        span_y9 = yu - yd;
        span_x  = span_x9[6:0];
        span_y  = span_y9[6:0];
    end

    // height store
    logic [ADDR_W-1:0] raddr;
    logic [15:0]       rdata;

    always_comb
    begin
        unique case (cmd.mem_sel)
            MS_XL:   raddr = {yq[7:0], xl[7:0]};
            MS_XR:   raddr = {yq[7:0], xr[7:0]};
            MS_YD:   raddr = {yd[7:0], xq[7:0]};
            MS_YU:   raddr = {yu[7:0], xq[7:0]};
            default: raddr = {yq[7:0], xq[7:0]};
        endcase
    end

    hnm_ram #(
        .WIDTH (16),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.mem_write),
        .waddr ({pixel_y, pixel_x}),
        .wdata (height_sample),
        .raddr (raddr),
        .rdata (rdata)
    );

    logic [15:0] h_reg [4];

    always_ff @(posedge clk)
    begin
        if (cmd.cap_en)
        begin
            h_reg[cmd.cap_sel] <= rdata;
        end
    end

    logic        dx_pos, dy_pos;
    logic [15:0] dx_mag, dy_mag;

    assign dx_pos = h_reg[MS_XR] > h_reg[MS_XL];
    assign dy_pos = h_reg[MS_YU] > h_reg[MS_YD];
    assign dx_mag = dx_pos ? (h_reg[MS_XR] - h_reg[MS_XL]) : (h_reg[MS_XL] - h_reg[MS_XR]);
    assign dy_mag = dy_pos ? (h_reg[MS_YU] - h_reg[MS_YD]) : (h_reg[MS_YD] - h_reg[MS_YU]);

    // shared multiplier and sum of squares
    logic [31:0] ax_reg, ay_reg;
    logic        px_reg, py_reg;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod_reg, sum_reg;

    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_DX:  begin mul_a = {16'd0, dx_mag}; mul_b = {8'd0, gx_reg}; end
            MUL_DY:  begin mul_a = {16'd0, dy_mag}; mul_b = {8'd0, gy_reg}; end
            MUL_AX:  begin mul_a = ax_reg;          mul_b = ax_reg;         end
            MUL_AY:  begin mul_a = ay_reg;          mul_b = ay_reg;         end
            default: begin mul_a = ax_reg;          mul_b = ax_reg;         end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.sum_init)
        begin
            sum_reg <= {2'b00, prod_reg[63:2]} + 64'h0000_0000_4000_0000;
        end
        else if (cmd.sum_add)
        begin
            sum_reg <= sum_reg + {2'b00, prod_reg[63:2]};
        end
    end

    // square root, two radicand bits a step
    logic [63:0] sq_rad_reg;
    logic [34:0] sq_rem_reg;
    logic [31:0] sq_root_reg;
    logic [5:0]  sq_cnt_reg;
    logic [34:0] sq_r4, sq_trial;
    logic        sq_ge;

    assign sq_r4    = {sq_rem_reg[32:0], sq_rad_reg[63:62]};
    assign sq_trial = {1'b0, sq_root_reg, 2'b01};
    assign sq_ge    = sq_r4 >= sq_trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_cnt_reg <= 6'd0;
        end
        else if (cmd.sqrt_load)
        begin
            sq_cnt_reg <= 6'd32;
        end
        else if (sq_cnt_reg != 6'd0)
        begin
            sq_cnt_reg <= sq_cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_load)
        begin
            sq_rad_reg  <= sum_reg;
            sq_rem_reg  <= 35'd0;
            sq_root_reg <= 32'd0;
        end
        else if (sq_cnt_reg != 6'd0)
        begin
            sq_rad_reg  <= {sq_rad_reg[61:0], 2'b00};
            sq_rem_reg  <= sq_ge ? (sq_r4 - sq_trial) : sq_r4;
            sq_root_reg <= {sq_root_reg[30:0], sq_ge};
        end
    end

    // shared restoring divider, one quotient bit a step
    logic [47:0] div_num_reg;
    logic [32:0] div_rem_reg;
    logic [31:0] div_den_reg;
    logic [5:0]  div_cnt_reg;
    logic [40:0] slope_sum;
    logic [32:0] slope_q, norm_v;
    logic [47:0] load_num;
    logic [31:0] load_den;
    logic [5:0]  load_cnt;
    logic [32:0] div_t;
    logic        div_ge;

    always_comb
    begin
        slope_sum = prod_reg[40:0];
        norm_v    = {1'b0, ax_reg};
        load_den  = sq_root_reg;
        load_cnt  = 6'd48;
        unique case (cmd.div_kind)
            DK_SLOPE_X:
            begin
                slope_sum = prod_reg[40:0] + {27'd0, span_x, 7'd0};
                load_den  = {25'd0, span_x};
                load_cnt  = 6'd33;
            end
            DK_SLOPE_Y:
            begin
                slope_sum = prod_reg[40:0] + {27'd0, span_y, 7'd0};
                load_den  = {25'd0, span_y};
                load_cnt  = 6'd33;
            end
            DK_NORM_X: norm_v = {1'b0, ax_reg};
            DK_NORM_Y: norm_v = {1'b0, ay_reg};
            DK_NORM_Z: norm_v = 33'd65536;
            default:   norm_v = {1'b0, ax_reg};
        endcase
        slope_q = slope_sum[40:8];
        if (cmd.div_kind == DK_SLOPE_X || cmd.div_kind == DK_SLOPE_Y)
        begin
            load_num = {slope_q, 15'd0};
        end
        else
        begin
            load_num = {1'b0, norm_v, 14'd0} + {17'd0, sq_root_reg[31:1]};
        end
    end

    assign div_t  = {div_rem_reg[31:0], div_num_reg[47]};
    assign div_ge = div_t >= {1'b0, div_den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= 6'd0;
        end
        else if (cmd.div_load)
        begin
            div_cnt_reg <= load_cnt;
        end
        else if (div_cnt_reg != 6'd0)
        begin
            div_cnt_reg <= div_cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            div_num_reg <= load_num;
            div_rem_reg <= 33'd0;
            div_den_reg <= load_den;
        end
        else if (div_cnt_reg != 6'd0)
        begin
            div_num_reg <= {div_num_reg[46:0], div_ge};
            div_rem_reg <= div_ge ? (div_t - {1'b0, div_den_reg}) : div_t;
        end
    end

    assign status.div_busy  = div_cnt_reg != 6'd0;
    assign status.sqrt_busy = sq_cnt_reg != 6'd0;

    // quotient results
    logic [16:0] offx_reg, offy_reg, offz_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.div_store)
        begin
            unique case (cmd.div_kind)
                DK_SLOPE_X:
                begin
                    ax_reg <= (span_x == 7'd0) ? 32'd0 : div_num_reg[31:0];
                    px_reg <= dx_pos;
                end
                DK_SLOPE_Y:
                begin
                    ay_reg <= (span_y == 7'd0) ? 32'd0 : div_num_reg[31:0];
                    py_reg <= dy_pos;
                end
                DK_NORM_X: offx_reg <= sat17(div_num_reg);
                DK_NORM_Y: offy_reg <= sat17(div_num_reg);
                DK_NORM_Z: offz_reg <= sat17(div_num_reg);
                default:   ;
            endcase
        end
    end

    // output codes
    logic [15:0] cx, cy, cz, ey;

    assign cx = encode(offx_reg, px_reg);
    assign cy = encode(offy_reg, py_reg);
    assign cz = encode(offz_reg, 1'b0);
    assign ey = encode(offy_reg, py_reg ^ rh_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            normal_x_code <= cx;
            normal_y_code <= cy;
            normal_z_code <= cz;
            export_red    <= cx;
            export_green  <= yup_reg ? cz : ey;
            export_blue   <= yup_reg ? ey : cz;
        end
    end

endmodule

// ===== design/hnm_ctrl.sv =====
`timescale 1ns / 1ps
// controller state machine sequencing reads, slopes, root and normalisation
module hnm_ctrl
    import hnm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    req_type,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy,
    output logic    done
);

    typedef enum logic [4:0] {
        S_IDLE, S_RD0, S_RD1, S_RD2, S_RD3, S_RD4,
        S_MULX, S_DIVX_LD, S_DIVX_WT, S_MULY, S_DIVY_LD, S_DIVY_WT,
        S_SQX, S_ACCX, S_SQY, S_ACCY, S_SQRT_LD, S_SQRT_WT,
        S_NX_LD, S_NX_WT, S_NY_LD, S_NY_WT, S_NZ_LD, S_NZ_WT, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, done_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (start && req_type) state_next = S_RD0;
            S_RD0:     state_next = S_RD1;
            S_RD1:     state_next = S_RD2;
            S_RD2:     state_next = S_RD3;
            S_RD3:     state_next = S_RD4;
            S_RD4:     state_next = S_MULX;
            S_MULX:    state_next = S_DIVX_LD;
            S_DIVX_LD: state_next = S_DIVX_WT;
            S_DIVX_WT: if (!status.div_busy) state_next = S_MULY;
            S_MULY:    state_next = S_DIVY_LD;
            S_DIVY_LD: state_next = S_DIVY_WT;
            S_DIVY_WT: if (!status.div_busy) state_next = S_SQX;
            S_SQX:     state_next = S_ACCX;
            S_ACCX:    state_next = S_SQY;
            S_SQY:     state_next = S_ACCY;
            S_ACCY:    state_next = S_SQRT_LD;
            S_SQRT_LD: state_next = S_SQRT_WT;
            S_SQRT_WT: if (!status.sqrt_busy) state_next = S_NX_LD;
            S_NX_LD:   state_next = S_NX_WT;
            S_NX_WT:   if (!status.div_busy) state_next = S_NY_LD;
            S_NY_LD:   state_next = S_NY_WT;
            S_NY_WT:   if (!status.div_busy) state_next = S_NZ_LD;
            S_NZ_LD:   state_next = S_NZ_WT;
            S_NZ_WT:   if (!status.div_busy) state_next = S_OUT;
            S_OUT:     state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= state_next != S_IDLE;
            done_reg  <= state_reg == S_OUT;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

    always_comb
    begin
        cmd = '0;
        cmd.mem_sel  = MS_XL;
        cmd.cap_sel  = MS_XL;
        cmd.mul_sel  = MUL_DX;
        cmd.div_kind = DK_SLOPE_X;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.mem_write   = start && !req_type;
                cmd.latch_query = start && req_type;
            end
            S_RD0:     cmd.mem_sel = MS_XL;
            S_RD1:     begin cmd.mem_sel = MS_XR; cmd.cap_en = 1'b1; cmd.cap_sel = MS_XL; end
            S_RD2:     begin cmd.mem_sel = MS_YD; cmd.cap_en = 1'b1; cmd.cap_sel = MS_XR; end
            S_RD3:     begin cmd.mem_sel = MS_YU; cmd.cap_en = 1'b1; cmd.cap_sel = MS_YD; end
            S_RD4:     begin cmd.cap_en = 1'b1; cmd.cap_sel = MS_YU; end
            S_MULX:    begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_DX; end
            S_DIVX_LD: begin cmd.div_load = 1'b1; cmd.div_kind = DK_SLOPE_X; end
            S_DIVX_WT: begin cmd.div_store = !status.div_busy; cmd.div_kind = DK_SLOPE_X; end
            S_MULY:    begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_DY; end
            S_DIVY_LD: begin cmd.div_load = 1'b1; cmd.div_kind = DK_SLOPE_Y; end
            S_DIVY_WT: begin cmd.div_store = !status.div_busy; cmd.div_kind = DK_SLOPE_Y; end
            S_SQX:     begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_AX; end
            S_ACCX:    cmd.sum_init = 1'b1;
            S_SQY:     begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_AY; end
            S_ACCY:    cmd.sum_add = 1'b1;
            S_SQRT_LD: cmd.sqrt_load = 1'b1;
            S_SQRT_WT: ;
            S_NX_LD:   begin cmd.div_load = 1'b1; cmd.div_kind = DK_NORM_X; end
            S_NX_WT:   begin cmd.div_store = !status.div_busy; cmd.div_kind = DK_NORM_X; end
            S_NY_LD:   begin cmd.div_load = 1'b1; cmd.div_kind = DK_NORM_Y; end
            S_NY_WT:   begin cmd.div_store = !status.div_busy; cmd.div_kind = DK_NORM_Y; end
            S_NZ_LD:   begin cmd.div_load = 1'b1; cmd.div_kind = DK_NORM_Z; end
            S_NZ_WT:   begin cmd.div_store = !status.div_busy; cmd.div_kind = DK_NORM_Z; end
            S_OUT:     cmd.out_load = 1'b1;
            default:   ;
        endcase
    end

endmodule

// ===== design/heightmap_normal_map_unit.sv =====
`timescale 1ns / 1ps
// top level of the height map normal unit
//
//  channel   handshake             word
//  request   start / busy          req_type, pixel_x, pixel_y, height_sample
//  result    done (one cycle)      normal_*_code, export_red/green/blue
//  config    cfg_write             cfg_index, cfg_data
//
// a write word is stored in the cycle it is taken, busy stays low
// a query runs from start to done through four store reads, two slope
// divides of 33 steps, a 32 step square root and three 48 step divides
// reset leaves the store contents undefined and loads the register defaults
// done cannot be held off; the next word may be taken in the done cycle
module heightmap_normal_map_unit
    import hnm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic        req_type,
    input  logic [7:0]  pixel_x,
    input  logic [7:0]  pixel_y,
    input  logic [15:0] height_sample,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    output logic [15:0] normal_x_code,
    output logic [15:0] normal_y_code,
    output logic [15:0] normal_z_code,
    output logic [15:0] export_red,
    output logic [15:0] export_green,
    output logic [15:0] export_blue
);

    cmd_t    cmd;
    status_t status;

    hnm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done)
    );

    hnm_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .height_sample (height_sample),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .normal_x_code (normal_x_code),
        .normal_y_code (normal_y_code),
        .normal_z_code (normal_z_code),
        .export_red    (export_red),
        .export_green  (export_green),
        .export_blue   (export_blue)
    );

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without a query in flight");

    a_write_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !req_type) |=> !done)
        else $error("write word produced a result");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type) |=> busy)
        else $error("query taken but unit not busy");

endmodule
